@@ hdl/sscf_pkg.sv @@
`default_nettype none

package sscf_pkg;

    // Framing constants
    localparam int          PAYLOAD_BYTES = 4;
    localparam int          BUF_IDX_W     = $clog2(PAYLOAD_BYTES);
    localparam int          POS_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [7:0]  START_BYTE    = 8'h80;
    localparam logic [7:0]  CRC_POLY      = 8'h8C;

    // Item kinds carried in the mode field
    localparam logic [1:0]  MODE_RX       = 2'd0;
    localparam logic [1:0]  MODE_LOAD_BUF = 2'd1;
    localparam logic [1:0]  MODE_LOAD_CRC = 2'd2;

    // Readback request codes
    localparam logic [1:0]  PREP_NONE     = 2'd0;
    localparam logic [1:0]  PREP_MOTOR    = 2'd1;
    localparam logic [1:0]  PREP_CURRENT  = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam int          REG_ADDR_W    = 5;
    localparam logic [2:0]  REG_OP_VERSION   = 3'd0;
    localparam logic [2:0]  REG_OP_MODE_SET  = 3'd1;
    localparam logic [2:0]  REG_OP_MOTOR_SET = 3'd2;
    localparam logic [2:0]  REG_OP_MOTOR_GET = 3'd3;
    localparam logic [2:0]  REG_OP_CURRENT   = 3'd4;
    localparam logic [2:0]  REG_VERSION_VAL  = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [1:0] load_index;
        logic [7:0] load_value;
    } item_word_t;

    typedef struct packed {
        logic [7:0]         tx_byte;
        logic               led_on;
        logic               mode_valid;
        logic [7:0]         mode_value;
        logic               motor_valid;
        logic signed [15:0] motor_a;
        logic signed [15:0] motor_b;
        logic [1:0]         prepare_request;
    } result_word_t;

    // Fold one byte into a reflected CRC-8 (Maxim polynomial)
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spi_slave_command_framer_top.sv @@
`default_nettype none
// Channel   Handshake                   Payload        Width
// item      item_valid / item_ready     item           20 bits, item_word_t
// result    result_valid / result_ready result         53 bits, result_word_t
// config    psel / penable / pwrite     paddr, pwdata  APB, 6 byte registers
//
// One word in, one word out; an item's result is registered in the cycle
// after accept, and a new item is taken every cycle while item_ready is high.
// The only stall is the result register: item_ready drops while a result
// waits and result_ready is low.
// Reset clears the framing state, the CRC and the LED, and loads the opcode
// and version registers with their defaults; the reply buffer holds nothing
// defined until loaded.
module spi_slave_command_framer_top
    import sscf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_word_t            item,

    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_word_t               result,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // Handler codes
    localparam logic [2:0] H_START    = 3'd0;
    localparam logic [2:0] H_VERSION  = 3'd1;
    localparam logic [2:0] H_MODESET  = 3'd2;
    localparam logic [2:0] H_MOTORSET = 3'd3;
    localparam logic [2:0] H_MOTORGET = 3'd4;
    localparam logic [2:0] H_CURRENT  = 3'd5;

    logic [7:0]           op_version_reg;
    logic [7:0]           op_mode_set_reg;
    logic [7:0]           op_motor_set_reg;
    logic [7:0]           op_motor_get_reg;
    logic [7:0]           op_current_reg;
    logic [7:0]           version_val_reg;

    logic [2:0]           handler_reg;
    logic [2:0]           handler_next;
    logic [POS_W-1:0]     position_reg;
    logic [POS_W-1:0]     position_next;
    logic [7:0]           crc_reg;
    logic [7:0]           crc_next;
    logic                 led_reg;
    logic                 led_next;
    logic [7:0]           buf_reg [PAYLOAD_BYTES];

    logic                 buf_we;
    logic [BUF_IDX_W-1:0] buf_waddr;
    logic [7:0]           buf_wdata;

    logic                 result_valid_reg;
    result_word_t         result_reg;
    result_word_t         result_next;

    logic                 item_fire;
    logic                 cfg_write;
    logic [2:0]           cfg_index;
    logic [POS_W-1:0]     need_bytes;

    assign item_ready   = !result_valid_reg || result_ready;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[REG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_version_reg   <= 8'd1;
            op_mode_set_reg  <= 8'd2;
            op_motor_set_reg <= 8'd3;
            op_motor_get_reg <= 8'd4;
            op_current_reg   <= 8'd5;
            version_val_reg  <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OP_VERSION:   op_version_reg   <= pwdata[7:0];
                REG_OP_MODE_SET:  op_mode_set_reg  <= pwdata[7:0];
                REG_OP_MOTOR_SET: op_motor_set_reg <= pwdata[7:0];
                REG_OP_MOTOR_GET: op_motor_get_reg <= pwdata[7:0];
                REG_OP_CURRENT:   op_current_reg   <= pwdata[7:0];
                REG_VERSION_VAL:  version_val_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_OP_VERSION:   prdata[7:0] = op_version_reg;
            REG_OP_MODE_SET:  prdata[7:0] = op_mode_set_reg;
            REG_OP_MOTOR_SET: prdata[7:0] = op_motor_set_reg;
            REG_OP_MOTOR_GET: prdata[7:0] = op_motor_get_reg;
            REG_OP_CURRENT:   prdata[7:0] = op_current_reg;
            REG_VERSION_VAL:  prdata[7:0] = version_val_reg;
            default:          prdata      = '0;
        endcase
    end

    // Frame decode, CRC and reply selection for one word
    always_comb
    begin
        handler_next  = handler_reg;
        position_next = position_reg;
        crc_next      = crc_reg;
        led_next      = led_reg;
        buf_we        = 1'b0;
        buf_waddr     = item.load_index;
        buf_wdata     = item.load_value;
        result_next   = '0;
        need_bytes    = (handler_reg == H_MODESET) ? POS_W'(1) : POS_W'(PAYLOAD_BYTES);

        case (item.mode)
            MODE_LOAD_BUF:
            begin
                buf_we = 1'b1;
            end
            MODE_LOAD_CRC:
            begin
                crc_next = item.load_value;
            end
            MODE_RX:
            begin
                result_next.tx_byte = item.rx_byte;
                case (handler_reg)
                    H_START:
                    begin
                        if (position_reg == '0)
                        begin
                            // Hunt for the start byte
                            if (item.rx_byte == START_BYTE)
                                position_next = POS_W'(1);
                            else
                                result_next.tx_byte = '0;
                        end
                        else
                        begin
                            // Dispatch on the opcode, first match wins
                            position_next = '0;
                            crc_next      = crc8_step(8'd0, item.rx_byte);
                            if (item.rx_byte == op_version_reg)
                                handler_next = H_VERSION;
                            else if (item.rx_byte == op_mode_set_reg)
                                handler_next = H_MODESET;
                            else if (item.rx_byte == op_motor_set_reg)
                                handler_next = H_MOTORSET;
                            else if (item.rx_byte == op_motor_get_reg)
                            begin
                                handler_next                = H_MOTORGET;
                                result_next.prepare_request = PREP_MOTOR;
                            end
                            else if (item.rx_byte == op_current_reg)
                            begin
                                handler_next                = H_CURRENT;
                                result_next.prepare_request = PREP_CURRENT;
                            end
                            else
                            begin
                                handler_next = H_START;
                                crc_next     = crc_reg;
                                led_next     = 1'b1;
                            end
                        end
                    end
                    H_VERSION:
                    begin
                        result_next.tx_byte = version_val_reg;
                        handler_next        = H_START;
                        position_next       = '0;
                        led_next            = 1'b0;
                    end
                    H_MODESET, H_MOTORSET:
                    begin
                        if (position_reg < need_bytes)
                        begin
                            // Store the data byte and fold it into the CRC
                            buf_we        = 1'b1;
                            buf_waddr     = position_reg[BUF_IDX_W-1:0];
                            buf_wdata     = item.rx_byte;
                            position_next = position_reg + POS_W'(1);
                            crc_next      = crc8_step(crc_reg, item.rx_byte);
                        end
                        else
                        begin
                            handler_next  = H_START;
                            position_next = '0;
                            if (item.rx_byte != crc_reg)
                                led_next = 1'b1;
                            else
                            begin
                                led_next = 1'b0;
                                if (handler_reg == H_MODESET)
                                begin
                                    result_next.mode_valid = 1'b1;
                                    result_next.mode_value = buf_reg[0];
                                end
                                else
                                begin
                                    result_next.motor_valid = 1'b1;
                                    result_next.motor_a     = {buf_reg[0], buf_reg[1]};
                                    result_next.motor_b     = {buf_reg[2], buf_reg[3]};
                                end
                            end
                        end
                    end
                    H_MOTORGET, H_CURRENT:
                    begin
                        if (position_reg < POS_W'(PAYLOAD_BYTES))
                        begin
                            // Stream the loaded buffer
                            result_next.tx_byte = buf_reg[position_reg[BUF_IDX_W-1:0]];
                            position_next       = position_reg + POS_W'(1);
                        end
                        else
                        begin
                            result_next.tx_byte = crc_reg;
                            handler_next        = H_START;
                            position_next       = '0;
                            led_next            = 1'b0;
                        end
                    end
                    default:
                    begin
                        handler_next  = H_START;
                        position_next = '0;
                    end
                endcase
            end
            default: ;
        endcase

        result_next.led_on = led_next;
    end

    // Advance framing state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_reg  <= H_START;
            position_reg <= '0;
            crc_reg      <= '0;
            led_reg      <= 1'b0;
        end
        else if (item_fire)
        begin
            handler_reg  <= handler_next;
            position_reg <= position_next;
            crc_reg      <= crc_next;
            led_reg      <= led_next;
        end
    end

    // Reply buffer, loaded by the host or by set commands
    always_ff @(posedge clk)
    begin
        if (item_fire && buf_we)
            buf_reg[buf_waddr] <= buf_wdata;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_ready)
            result_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire
